@@ design/mbe_pkg.sv @@
`timescale 1ns / 1ps

package mbe_pkg;

    // Fixed-point format of coordinates and iterates
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 16;

    // Shared multiplier: signed operands one bit wider than a word
    localparam int MUL_W   = WORD_W + 1;
    localparam int PROD_W  = 2 * WORD_W;
    // Wide working width for sums before saturation
    localparam int SUM_W   = PROD_W + 2;
    // Squares after the fraction shift, and twice the cross product
    localparam int SQ_W    = PROD_W + 1 - FRAC_BITS;
    localparam int XY_W    = PROD_W + 2 - FRAC_BITS;

    // Escape radius squared: 4.0 in the fixed-point format
    localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(64'd4 << FRAC_BITS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_EDGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 3'd4;

    localparam logic [COUNT_W-1:0] MAX_ITERS_RESET = 16'd10000;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    escape_count;
        logic [COORD_BITS-1:0] out_col;
        logic [COORD_BITS-1:0] out_row;
    } pixel_out_t;

    // Clamp a wide signed value to the signed word range
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = {{(SUM_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
        lo = {{(SUM_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
        if (v > hi)
            sat_word = hi[WORD_W-1:0];
        else if (v < lo)
            sat_word = lo[WORD_W-1:0];
        else
            sat_word = v[WORD_W-1:0];
    endfunction

endpackage

@@ design/mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data   (pixel_col, pixel_row)
// out       output     out_valid / out_stall  out_data  (escape_count, out_col, out_row)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After its accept a pixel runs through these states, n being its escape count:
// CRE and CIM form c, then each of the n iterations and the closing escape test
// uses the single shared 33x33 multiplier in SQX, SQY and STEP (x*x, y*y, x*y),
// FIN moves the result to the output register and IDLE takes the next pixel.
// The input stalls while a pixel is in work. A finished result sits in the output
// register; the next pixel is taken while it waits, and the following pixel holds
// in its FIN state until that result leaves. Reset clears the handshake state
// and loads the register reset values (max_iters = 10000, edges and steps zero).
module mandelbrot_escape_time (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  mbe_pkg::pixel_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output mbe_pkg::pixel_out_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbe_pkg::WORD_W-1:0]          cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CRE  = 3'd1;
    localparam logic [2:0] ST_CIM  = 3'd2;
    localparam logic [2:0] ST_SQX  = 3'd3;
    localparam logic [2:0] ST_SQY  = 3'd4;
    localparam logic [2:0] ST_STEP = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam int W  = mbe_pkg::WORD_W;
    localparam int SW = mbe_pkg::SUM_W;

    logic [2:0]                        state_reg, state_next;
    logic [mbe_pkg::COUNT_W-1:0]       max_iters_reg;
    logic signed [W-1:0]               left_edge_reg, lower_edge_reg, step_x_reg, step_y_reg;
    logic [mbe_pkg::COORD_BITS-1:0]    col_reg, row_reg;
    logic signed [W-1:0]               cre_reg, cim_reg, x_reg, y_reg;
    logic signed [mbe_pkg::SQ_W-1:0]   xx_reg, yy_reg;
    logic [mbe_pkg::COUNT_W-1:0]       count_reg;
    logic                              out_valid_reg;
    mbe_pkg::pixel_out_t               out_data_reg;

    logic signed [mbe_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [2*mbe_pkg::MUL_W-1:0] mul_full;
    logic signed [mbe_pkg::PROD_W-1:0] prod;
    logic signed [mbe_pkg::SQ_W-1:0]   sq_shift;
    logic signed [mbe_pkg::XY_W-1:0]   xy_shift;
    logic signed [SW-1:0]              c_sum, nx_sum, ny_sum, len_sum;
    logic                              in_take, out_free, escaped, limit_hit;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Select operands for the shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_CRE:
            begin
                mul_a = $signed({{(mbe_pkg::MUL_W-mbe_pkg::COORD_BITS){1'b0}}, col_reg});
                mul_b = {step_x_reg[W-1], step_x_reg};
            end
            ST_CIM:
            begin
                mul_a = $signed({{(mbe_pkg::MUL_W-mbe_pkg::COORD_BITS){1'b0}}, row_reg});
                mul_b = {step_y_reg[W-1], step_y_reg};
            end
            ST_SQX:
            begin
                mul_a = {x_reg[W-1], x_reg};
                mul_b = {x_reg[W-1], x_reg};
            end
            ST_SQY:
            begin
                mul_a = {y_reg[W-1], y_reg};
                mul_b = {y_reg[W-1], y_reg};
            end
            default:
            begin
                mul_a = {x_reg[W-1], x_reg};
                mul_b = {y_reg[W-1], y_reg};
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign prod     = mul_full[mbe_pkg::PROD_W-1:0];
    // Floor shifts: arithmetic right shift rounds toward minus infinity
    assign sq_shift = mbe_pkg::SQ_W'(prod >>> mbe_pkg::FRAC_BITS);
    assign xy_shift = mbe_pkg::XY_W'(prod >>> (mbe_pkg::FRAC_BITS - 1));

    // Form c, the next iterate and the squared magnitude
    always_comb
    begin
        c_sum   = SW'(prod) + SW'(state_reg == ST_CRE ? left_edge_reg : lower_edge_reg);
        nx_sum  = SW'(xx_reg) - SW'(yy_reg) + SW'(cre_reg);
        ny_sum  = SW'(xy_shift) + SW'(cim_reg);
        len_sum = SW'(xx_reg) + SW'(yy_reg);
    end

    assign escaped   = (mbe_pkg::PROD_W'(len_sum) >= $signed(mbe_pkg::ESCAPE_LIMIT));
    assign limit_hit = (count_reg >= max_iters_reg);

    // Sequence one pixel through the shared multiplier
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_CRE;
            ST_CRE:  state_next = ST_CIM;
            ST_CIM:  state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_STEP;
            ST_STEP: state_next = (escaped || limit_hit) ? ST_FIN : ST_SQX;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold control state and the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            max_iters_reg  <= mbe_pkg::MAX_ITERS_RESET;
            left_edge_reg  <= '0;
            lower_edge_reg <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mbe_pkg::CFG_MAX_ITERS:  max_iters_reg  <= cfg_data[mbe_pkg::COUNT_W-1:0];
                    mbe_pkg::CFG_LEFT_EDGE:  left_edge_reg  <= cfg_data;
                    mbe_pkg::CFG_LOWER_EDGE: lower_edge_reg <= cfg_data;
                    mbe_pkg::CFG_STEP_X:     step_x_reg     <= cfg_data;
                    mbe_pkg::CFG_STEP_Y:     step_y_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_CIM)
                count_reg <= '0;
            else if (state_reg == ST_STEP && !escaped && !limit_hit)
                count_reg <= count_reg + 1'b1;
        end
    end

    // Advance the datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    col_reg <= in_data.pixel_col;
                    row_reg <= in_data.pixel_row;
                end
            end
            ST_CRE: cre_reg <= mbe_pkg::sat_word(c_sum);
            ST_CIM:
            begin
                cim_reg <= mbe_pkg::sat_word(c_sum);
                x_reg   <= '0;
                y_reg   <= '0;
            end
            ST_SQX: xx_reg <= sq_shift;
            ST_SQY: yy_reg <= sq_shift;
            ST_STEP:
            begin
                if (!escaped && !limit_hit)
                begin
                    x_reg <= mbe_pkg::sat_word(nx_sum);
                    y_reg <= mbe_pkg::sat_word(ny_sum);
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg.escape_count <= count_reg;
                    out_data_reg.out_col      <= col_reg;
                    out_data_reg.out_row      <= row_reg;
                end
            end
            default: ;
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |-> (count_reg <= max_iters_reg))
        else $error("iteration count passed the limit");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.escape_count <= max_iters_reg))
        else $error("result count above the limit");

    a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && !out_valid_reg |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished pixel not moved to the output register");

    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while a pixel is in work");

endmodule

@@ dv/mbe_escape_checker.sv @@
`timescale 1ns / 1ps

module mbe_escape_checker
    import mbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  pixel_in_t            in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  pixel_out_t           out_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   pending,
    output int                   fail_count
);

    localparam int     REPORT_LIMIT = 10;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;
    localparam longint ESCAPE_BOUND = 64'sd4 <<< FRAC_BITS;

    // Register copies, taken from the configuration port
    logic [COUNT_W-1:0]       iter_limit;
    logic signed [WORD_W-1:0] re_origin;
    logic signed [WORD_W-1:0] im_origin;
    logic signed [WORD_W-1:0] re_pitch;
    logic signed [WORD_W-1:0] im_pitch;

    pixel_out_t expected_pixels_q[$];
    int         mismatches;

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // Iterate z = z^2 + c from zero until |z|^2 reaches 4 or the limit is hit
    function automatic logic [COUNT_W-1:0] escape_iterations(
        input logic [COORD_BITS-1:0] col,
        input logic [COORD_BITS-1:0] row
    );
        longint      c_re;
        longint      c_im;
        longint      x;
        longint      y;
        longint      x_sq;
        longint      y_sq;
        longint      cross2;
        longint      radius_sq;
        int unsigned n;
        c_re = clamp_word(longint'(re_origin) + longint'(col) * longint'(re_pitch));
        c_im = clamp_word(longint'(im_origin) + longint'(row) * longint'(im_pitch));
        x = 0;
        y = 0;
        radius_sq = 0;
        n = 0;
        while (n < iter_limit && radius_sq < ESCAPE_BOUND)
        begin
            // arithmetic shifts give floor rounding on negative products
            x_sq   = (x * x) >>> FRAC_BITS;
            y_sq   = (y * y) >>> FRAC_BITS;
            cross2 = (x * y) >>> (FRAC_BITS - 1);
            x = clamp_word(x_sq - y_sq + c_re);
            y = clamp_word(cross2 + c_im);
            radius_sq = ((x * x) >>> FRAC_BITS) + ((y * y) >>> FRAC_BITS);
            n++;
        end
        return COUNT_W'(n);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_out_t want;
        logic       bad;
        if (!rst_n)
        begin
            iter_limit = MAX_ITERS_RESET;
            re_origin  = '0;
            im_origin  = '0;
            re_pitch   = '0;
            im_pitch   = '0;
            expected_pixels_q.delete();
            mismatches = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            // Track register writes; unused indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_ITERS:  iter_limit = cfg_data[COUNT_W-1:0];
                    CFG_LEFT_EDGE:  re_origin  = cfg_data;
                    CFG_LOWER_EDGE: im_origin  = cfg_data;
                    CFG_STEP_X:     re_pitch   = cfg_data;
                    CFG_STEP_Y:     im_pitch   = cfg_data;
                    default:        ;
                endcase
            end

            // Compare a delivered item with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_pixels_q.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: count %0d col %0d row %0d",
                                 out_data.escape_count, out_data.out_col, out_data.out_row);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels_q.pop_front();
                    bad = (out_data.escape_count !== want.escape_count)
                       || (out_data.out_col !== want.out_col)
                       || (out_data.out_row !== want.out_row);
                    if (bad)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("mismatch: expected count %0d col %0d row %0d, got count %0d col %0d row %0d",
                                     want.escape_count, want.out_col, want.out_row,
                                     out_data.escape_count, out_data.out_col, out_data.out_row);
                        mismatches++;
                    end
                end
            end

            // Predict the result of each accepted pixel
            if (in_valid && !in_stall)
            begin
                want.escape_count = escape_iterations(in_data.pixel_col, in_data.pixel_row);
                want.out_col      = in_data.pixel_col;
                want.out_row      = in_data.pixel_row;
                expected_pixels_q.push_back(want);
            end

            pending    <= expected_pixels_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ dv/tb_mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;

    import mbe_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int GROUP_ITEMS = 33;
    localparam int UNIT        = 1 << FRAC_BITS;
    // View covering the whole set: [-2, 0.5] x [-1.25, 1.25]
    localparam int STD_LEFT    = -2 * UNIT;
    localparam int STD_LOWER   = -(5 * UNIT) / 4;
    localparam int STD_STEP    = (5 * UNIT / 2) >> COORD_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pixel_in_t            in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pixel_out_t           out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;
    int                   pending;
    int                   fail_count;
    int                   cycles    = 0;
    int                   in_gap_pct  = 24;
    int                   out_hold_pct = 66;

    mandelbrot_escape_time i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mbe_escape_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < out_hold_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_mandelbrot_escape_time NOT OK");
            $finish;
        end
    end

    // Offer one pixel, with a random gap first; leave valid high afterwards
    task automatic push_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row);
        if ($urandom_range(99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_gap_pct);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel_col: col, pixel_row: row};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load all registers, plus a write to an unused index that must be dropped
    task automatic load_config(input logic [COUNT_W-1:0] limit,
                               input logic [WORD_W-1:0]  left,
                               input logic [WORD_W-1:0]  lower,
                               input logic [WORD_W-1:0]  sx,
                               input logic [WORD_W-1:0]  sy);
        write_reg(CFG_MAX_ITERS, {16'($urandom()), limit});
        write_reg(CFG_LEFT_EDGE, left);
        write_reg(CFG_LOWER_EDGE, lower);
        write_reg(CFG_STEP_X, sx);
        write_reg(CFG_STEP_Y, sy);
        write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(2)), $urandom());
        cfg_valid <= 1'b0;
    endtask

    // Pick a jittered full view most of the time, otherwise anything at all
    task automatic pick_view();
        if ($urandom_range(3) == 0)
            load_config(16'($urandom_range(100)), $urandom(), $urandom(),
                        $urandom(), $urandom());
        else
            load_config(16'($urandom_range(1, 100)),
                        STD_LEFT + int'($urandom_range(UNIT / 4)),
                        STD_LOWER + int'($urandom_range(UNIT / 4)),
                        STD_STEP / 2 + int'($urandom_range(STD_STEP)),
                        STD_STEP / 2 + int'($urandom_range(STD_STEP)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: c is zero, so the pixel runs to the reset limit
        push_pixel(12'd0, 12'd0);
        settle();

        // Limit of one: every pixel answers one
        load_config(16'd1, STD_LEFT, STD_LOWER, STD_STEP, STD_STEP);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd2048, 12'd2048);
        settle();

        // Zero limit: no iteration at all
        load_config(16'd0, STD_LEFT, STD_LOWER, STD_STEP, STD_STEP);
        push_pixel(12'd0, 12'd4095);
        push_pixel(12'd4095, 12'd0);
        settle();

        // Largest limit with c saturating: positive real, negative imaginary
        load_config(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd1, 12'd1);
        settle();

        // And the opposite corners of the coordinate range
        load_config(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        push_pixel(12'd4095, 12'd4095);
        push_pixel(12'd0, 12'd1);
        settle();

        // Just right of the cusp at 0.25: slow escape, hundreds of iterations
        load_config(16'hFFFF, UNIT / 4 + (UNIT >> 12), 32'd0, UNIT >> 8, 32'd0);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd1, 12'd7);
        push_pixel(12'd4095, 12'd0);
        settle();

        // Unit steps from -2: exact boundary at -2, limit hits at -1 and i, quick escape at 1
        load_config(16'd40, STD_LEFT, 32'd0, UNIT, UNIT / 4);
        push_pixel(12'd0, 12'd0);
        push_pixel(12'd1, 12'd0);
        push_pixel(12'd3, 12'd0);
        push_pixel(12'd2, 12'd4);
        push_pixel(12'd4095, 12'd4095);
        settle();

        // Random pixels under three idling profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin in_gap_pct = 24; out_hold_pct = 66; end
                1:       begin in_gap_pct = 66; out_hold_pct = 24; end
                default: begin in_gap_pct = 0;  out_hold_pct = 0;  end
            endcase
            for (int grp = 0; grp < 4; grp++)
            begin
                pick_view();
                repeat (GROUP_ITEMS)
                    push_pixel(COORD_BITS'($urandom_range(4095)),
                               COORD_BITS'($urandom_range(4095)));
                settle();
            end
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_mandelbrot_escape_time OK");
        else
            $display("tb_mandelbrot_escape_time NOT OK");
        $finish;
    end

endmodule
